@@ hdl/bsp_pkg.sv @@
package bsp_pkg;

  localparam int NODE_DEPTH  = 1024;
  localparam int PLANE_DEPTH = 1024;
  localparam int STACK_DEPTH = 32;
  localparam int LEAF_LIMIT  = 64;
  localparam int BAND        = 16;
  localparam int WALK_LIMIT  = 4096;

  localparam int NODE_AW  = $clog2(NODE_DEPTH);
  localparam int PLANE_AW = $clog2(PLANE_DEPTH);
  localparam int STACK_AW = $clog2(STACK_DEPTH);
  localparam int SP_W     = $clog2(STACK_DEPTH + 1);
  localparam int WALK_W   = $clog2(WALK_LIMIT + 1);
  localparam int TOTAL_W  = 7;

  // Stack entry: child reference followed by start and end of the piece.
  localparam int STK_W = 16 + 6 * 32;

  // Index of the last step of each iterated unit.
  localparam int DIST_LAST = 6;
  localparam int DIV_LAST  = 30;
  localparam int MID_LAST  = 3;

  typedef enum logic [1:0] {
    OP_WR_NODE  = 2'd0,
    OP_WR_PLANE = 2'd1,
    OP_QUERY    = 2'd2,
    OP_NONE     = 2'd3
  } bsp_op_t;

  typedef enum logic [1:0] {
    KIND_ACK  = 2'd0,
    KIND_LEAF = 2'd1,
    KIND_NONE = 2'd2
  } bsp_kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POP,
    S_LOAD,
    S_NODE,
    S_PLANE,
    S_DIST,
    S_CLASS,
    S_NORM,
    S_DIV,
    S_MID,
    S_PUSH_F,
    S_PUSH_B,
    S_FINISH
  } bsp_state_t;

  typedef struct packed {
    logic       wr_node;
    logic       wr_plane;
    logic       q_init;
    logic       pop;
    logic       ovf_set;
    logic       emit_leaf;
    logic       node_rd;
    logic       plane_rd;
    logic       dist_init;
    logic       dist_step;
    logic       class_ld;
    logic       norm_step;
    logic       div_step;
    logic       mid_step;
    logic       push_front;
    logic       push_back;
    logic       finish;
    logic [4:0] step;
  } bsp_cmd_t;

  typedef struct packed {
    logic sp_zero;
    logic walk_done;
    logic ref_leaf;
    logic ref_empty;
    logic leaf_full;
    logic node_oob;
    logic spans;
    logic den_small;
  } bsp_status_t;

endpackage

@@ hdl/bsp_ctrl.sv @@
module bsp_ctrl
  import bsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [1:0]  in_operation,
  input  bsp_status_t status,
  output bsp_cmd_t    cmd,
  output logic        busy
);

  bsp_state_t state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = '0;
    cmd       = '0;
    cmd.step  = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (bsp_op_t'(in_operation))
            OP_WR_NODE:  cmd.wr_node = 1'b1;
            OP_WR_PLANE: cmd.wr_plane = 1'b1;
            OP_QUERY: begin
              cmd.q_init = 1'b1;
              state_nxt  = S_POP;
            end
            default: ;
          endcase
        end
      end
      S_POP: begin
        if (status.sp_zero) begin
          state_nxt = S_FINISH;
        end else if (status.walk_done) begin
          cmd.ovf_set = 1'b1;
          state_nxt   = S_FINISH;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        if (status.ref_leaf) begin
          if (status.ref_empty) begin
            state_nxt = S_POP;
          end else if (status.leaf_full) begin
            cmd.ovf_set = 1'b1;
            state_nxt   = S_FINISH;
          end else begin
            cmd.emit_leaf = 1'b1;
            state_nxt     = S_POP;
          end
        end else if (status.node_oob) begin
          state_nxt = S_POP;
        end else begin
          cmd.node_rd = 1'b1;
          state_nxt   = S_NODE;
        end
      end
      S_NODE: begin
        cmd.plane_rd = 1'b1;
        state_nxt    = S_PLANE;
      end
      S_PLANE: begin
        cmd.dist_init = 1'b1;
        state_nxt     = S_DIST;
      end
      S_DIST: begin
        cmd.dist_step = 1'b1;
        if (cnt_r == 5'(DIST_LAST)) begin
          state_nxt = S_CLASS;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_CLASS: begin
        if (status.spans) begin
          cmd.class_ld = 1'b1;
          state_nxt    = S_NORM;
        end else begin
          state_nxt = S_PUSH_F;
        end
      end
      S_NORM: begin
        if (status.den_small) begin
          state_nxt = S_DIV;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == 5'(DIV_LAST)) begin
          state_nxt = S_MID;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_MID: begin
        cmd.mid_step = 1'b1;
        if (cnt_r == 5'(MID_LAST)) begin
          state_nxt = S_PUSH_F;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_PUSH_F: begin
        cmd.push_front = 1'b1;
        state_nxt      = S_PUSH_B;
      end
      S_PUSH_B: begin
        cmd.push_back = 1'b1;
        state_nxt     = S_POP;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

@@ hdl/bsp_dp.sv @@
module bsp_dp
  import bsp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  bsp_cmd_t           cmd,
  output bsp_status_t        status,
  input  logic [9:0]         in_entry_index,
  input  logic signed [31:0] in_coord_a_x,
  input  logic signed [31:0] in_coord_a_y,
  input  logic signed [31:0] in_coord_a_z,
  input  logic signed [31:0] in_coord_b_x,
  input  logic signed [31:0] in_coord_b_y,
  input  logic signed [31:0] in_coord_b_z,
  input  logic [9:0]         in_node_plane,
  input  logic [15:0]        in_child_back,
  input  logic [15:0]        in_child_front,
  output logic               out_valid,
  output logic [1:0]         out_kind,
  output logic [14:0]        out_leaf_index,
  output logic signed [31:0] out_piece_start_x,
  output logic signed [31:0] out_piece_start_y,
  output logic signed [31:0] out_piece_start_z,
  output logic signed [31:0] out_piece_end_x,
  output logic signed [31:0] out_piece_end_y,
  output logic signed [31:0] out_piece_end_z,
  output logic               out_last,
  output logic [6:0]         out_leaf_total,
  output logic               out_overflow
);

  // Tables and work stack.
  logic [41:0]      node_mem  [NODE_DEPTH];
  logic [127:0]     plane_mem [PLANE_DEPTH];
  logic [STK_W-1:0] stk_mem   [STACK_DEPTH];

  logic [41:0]      node_rd_r;
  logic [127:0]     plane_rd_r;
  logic             plane_ok_r;
  logic [STK_W-1:0] stk_rd_r;

  logic [SP_W-1:0]    sp_r;
  logic [TOTAL_W-1:0] n_r;
  logic               ovf_r;
  logic [WALK_W-1:0]  visits_r;

  logic signed [51:0] acc0_r, acc1_r;
  logic [52:0]        m0_r, den_r;
  logic [31:0]        rem_r;
  logic [30:0]        q_r;
  logic signed [64:0] prod_r;
  logic signed [31:0] mid_r [3];

  logic               pend_valid_r;
  logic [14:0]        pend_leaf_r;
  logic signed [31:0] pend_p0_r [3];
  logic signed [31:0] pend_p1_r [3];
  logic [TOTAL_W-1:0] pend_total_r;
  logic               pend_ovf_r;

  logic               out_valid_r;
  logic [1:0]         out_kind_r;
  logic [14:0]        out_leaf_r;
  logic signed [31:0] out_p0_r [3];
  logic signed [31:0] out_p1_r [3];
  logic               out_last_r;
  logic [TOTAL_W-1:0] out_total_r;
  logic               out_ovf_r;

  logic [15:0]        cur_ref;
  logic signed [31:0] p0 [3];
  logic signed [31:0] p1 [3];
  logic               f0b, f0f, f1b, f1f;
  logic               push_cond, push_ok;
  logic [15:0]        push_ref;
  logic signed [31:0] q0 [3];
  logic signed [31:0] q1 [3];
  logic               stk_we;
  logic [STK_W-1:0]   stk_wdata;
  logic [STACK_AW-1:0] stk_waddr;
  logic signed [32:0] mul_a;
  logic signed [31:0] mul_b;
  logic [52:0]        mag0, mag1;
  logic [31:0]        div_r;
  logic               div_ge;
  logic [9:0]         cur_plane;

  assign cur_ref = stk_rd_r[STK_W-1 -: 16];
  assign p0[0] = stk_rd_r[191:160];
  assign p0[1] = stk_rd_r[159:128];
  assign p0[2] = stk_rd_r[127:96];
  assign p1[0] = stk_rd_r[95:64];
  assign p1[1] = stk_rd_r[63:32];
  assign p1[2] = stk_rd_r[31:0];
  assign cur_plane = node_rd_r[41:32];

  // Sides of each endpoint against the plane band.
  assign f0b = acc0_r < -BAND;
  assign f0f = acc0_r > BAND;
  assign f1b = acc1_r < -BAND;
  assign f1f = acc1_r > BAND;

  assign mag0 = acc0_r[51] ? 53'(-acc0_r) : 53'(acc0_r);
  assign mag1 = acc1_r[51] ? 53'(-acc1_r) : 53'(acc1_r);

  always_comb begin
    status.sp_zero   = (sp_r == '0);
    status.walk_done = (visits_r >= WALK_W'(WALK_LIMIT));
    status.ref_leaf  = cur_ref[15];
    status.ref_empty = (cur_ref == 16'hFFFF);
    status.leaf_full = (n_r >= TOTAL_W'(LEAF_LIMIT));
    status.node_oob  = ({17'd0, cur_ref[14:0]} >= 32'(NODE_DEPTH));
    status.spans     = (f0b && f1f) || (f0f && f1b);
    status.den_small = (den_r[52:31] == '0);
  end

  // Child selection: front side is pushed first so that the back side pops first.
  always_comb begin
    if (cmd.push_front) begin
      push_cond = f0f || f1f || (!f0b && !f1b);
      push_ref  = node_rd_r[15:0];
      for (int k = 0; k < 3; k++) begin
        q0[k] = f0b ? mid_r[k] : p0[k];
        q1[k] = f1b ? mid_r[k] : p1[k];
      end
    end else begin
      push_cond = f0b || f1b || (!f0f && !f1f);
      push_ref  = node_rd_r[31:16];
      for (int k = 0; k < 3; k++) begin
        q0[k] = f0f ? mid_r[k] : p0[k];
        q1[k] = f1f ? mid_r[k] : p1[k];
      end
    end
  end

  assign push_ok = (cmd.push_front || cmd.push_back) && push_cond;

  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = sp_r[STACK_AW-1:0];
    stk_wdata = {push_ref, q0[0], q0[1], q0[2], q1[0], q1[1], q1[2]};
    if (cmd.q_init) begin
      stk_we    = 1'b1;
      stk_waddr = '0;
      stk_wdata = {6'd0, in_entry_index, in_coord_a_x, in_coord_a_y, in_coord_a_z,
                   in_coord_b_x, in_coord_b_y, in_coord_b_z};
    end else if (push_ok && (sp_r < SP_W'(STACK_DEPTH))) begin
      stk_we = 1'b1;
    end
  end

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.dist_step) begin
      case (cmd.step)
        5'd0: begin mul_a = 33'(p0[0]); mul_b = plane_rd_r[127:96]; end
        5'd1: begin mul_a = 33'(p0[1]); mul_b = plane_rd_r[95:64]; end
        5'd2: begin mul_a = 33'(p0[2]); mul_b = plane_rd_r[63:32]; end
        5'd3: begin mul_a = 33'(p1[0]); mul_b = plane_rd_r[127:96]; end
        5'd4: begin mul_a = 33'(p1[1]); mul_b = plane_rd_r[95:64]; end
        5'd5: begin mul_a = 33'(p1[2]); mul_b = plane_rd_r[63:32]; end
        default: ;
      endcase
      if (!plane_ok_r) mul_b = '0;
    end else begin
      case (cmd.step)
        5'd0: mul_a = 33'(p1[0]) - 33'(p0[0]);
        5'd1: mul_a = 33'(p1[1]) - 33'(p0[1]);
        5'd2: mul_a = 33'(p1[2]) - 33'(p0[2]);
        default: ;
      endcase
      mul_b = $signed({1'b0, q_r});
    end
  end

  // One restoring division step.
  assign div_r  = (cmd.step == '0) ? m0_r[31:0] : {rem_r[30:0], 1'b0};
  assign div_ge = (div_r >= {1'b0, den_r[30:0]});

  always_ff @(posedge clk) begin
    if (cmd.wr_node && (32'(in_entry_index) < 32'(NODE_DEPTH))) begin
      node_mem[NODE_AW'(in_entry_index)] <= {in_node_plane, in_child_back, in_child_front};
    end
    if (cmd.node_rd) begin
      node_rd_r <= node_mem[cur_ref[NODE_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_plane && (32'(in_entry_index) < 32'(PLANE_DEPTH))) begin
      plane_mem[PLANE_AW'(in_entry_index)] <= {in_coord_a_x, in_coord_a_y, in_coord_a_z,
                                               in_coord_b_x};
    end
    if (cmd.plane_rd) begin
      plane_rd_r <= plane_mem[PLANE_AW'(cur_plane)];
      plane_ok_r <= (32'(cur_plane) < 32'(PLANE_DEPTH));
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (cmd.pop) begin
      stk_rd_r <= stk_mem[STACK_AW'(sp_r - SP_W'(1))];
    end
  end

  // Arithmetic datapath.
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (cmd.dist_init) begin
      acc0_r <= plane_ok_r ? -52'(signed'(plane_rd_r[31:0])) : '0;
      acc1_r <= plane_ok_r ? -52'(signed'(plane_rd_r[31:0])) : '0;
    end
    if (cmd.dist_step && (cmd.step != '0)) begin
      if (cmd.step >= 5'd4) acc1_r <= acc1_r + 52'(prod_r >>> 16);
      else                  acc0_r <= acc0_r + 52'(prod_r >>> 16);
    end
    if (cmd.class_ld) begin
      m0_r  <= mag0;
      den_r <= mag0 + mag1;
    end
    if (cmd.norm_step) begin
      m0_r  <= m0_r >> 1;
      den_r <= den_r >> 1;
    end
    if (cmd.div_step) begin
      rem_r <= div_ge ? (div_r - {1'b0, den_r[30:0]}) : div_r;
      q_r   <= {q_r[29:0], div_ge};
    end
    if (cmd.mid_step && (cmd.step != '0)) begin
      case (cmd.step)
        5'd1: mid_r[0] <= p0[0] + 32'(prod_r >>> 30);
        5'd2: mid_r[1] <= p0[1] + 32'(prod_r >>> 30);
        5'd3: mid_r[2] <= p0[2] + 32'(prod_r >>> 30);
        default: ;
      endcase
    end
  end

  // Walk control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r         <= '0;
      n_r          <= '0;
      ovf_r        <= 1'b0;
      visits_r     <= '0;
      pend_valid_r <= 1'b0;
    end else begin
      if (cmd.q_init) begin
        sp_r         <= SP_W'(1);
        n_r          <= '0;
        ovf_r        <= 1'b0;
        visits_r     <= '0;
        pend_valid_r <= 1'b0;
      end
      if (cmd.pop) begin
        sp_r     <= sp_r - SP_W'(1);
        visits_r <= visits_r + WALK_W'(1);
      end
      if (cmd.ovf_set) ovf_r <= 1'b1;
      if (push_ok) begin
        if (sp_r < SP_W'(STACK_DEPTH)) sp_r <= sp_r + SP_W'(1);
        else                           ovf_r <= 1'b1;
      end
      if (cmd.emit_leaf) begin
        n_r          <= n_r + TOTAL_W'(1);
        pend_valid_r <= 1'b1;
      end
      if (cmd.finish) pend_valid_r <= 1'b0;
    end
  end

  // Pending leaf: held back one step so that the final one can carry last.
  always_ff @(posedge clk) begin
    if (cmd.emit_leaf) begin
      pend_leaf_r  <= cur_ref[14:0];
      pend_p0_r    <= p0;
      pend_p1_r    <= p1;
      pend_total_r <= n_r + TOTAL_W'(1);
      pend_ovf_r   <= ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.wr_node || cmd.wr_plane || cmd.finish ||
                     (cmd.emit_leaf && pend_valid_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_node || cmd.wr_plane) begin
      out_kind_r  <= KIND_ACK;
      out_leaf_r  <= '0;
      out_p0_r    <= '{default: '0};
      out_p1_r    <= '{default: '0};
      out_last_r  <= 1'b1;
      out_total_r <= '0;
      out_ovf_r   <= 1'b0;
    end else if ((cmd.emit_leaf || cmd.finish) && pend_valid_r) begin
      out_kind_r  <= KIND_LEAF;
      out_leaf_r  <= pend_leaf_r;
      out_p0_r    <= pend_p0_r;
      out_p1_r    <= pend_p1_r;
      out_last_r  <= cmd.finish;
      out_total_r <= pend_total_r;
      out_ovf_r   <= cmd.finish ? ovf_r : pend_ovf_r;
    end else if (cmd.finish) begin
      out_kind_r  <= KIND_NONE;
      out_leaf_r  <= '0;
      out_p0_r    <= '{default: '0};
      out_p1_r    <= '{default: '0};
      out_last_r  <= 1'b1;
      out_total_r <= '0;
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_leaf_index    = out_leaf_r;
  assign out_piece_start_x = out_p0_r[0];
  assign out_piece_start_y = out_p0_r[1];
  assign out_piece_start_z = out_p0_r[2];
  assign out_piece_end_x   = out_p1_r[0];
  assign out_piece_end_y   = out_p1_r[1];
  assign out_piece_end_z   = out_p1_r[2];
  assign out_last          = out_last_r;
  assign out_leaf_total    = out_total_r;
  assign out_overflow      = out_ovf_r;

  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SP_W'(STACK_DEPTH))
    else $error("work stack pointer past its depth");

  a_leaf_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= TOTAL_W'(LEAF_LIMIT))
    else $error("leaf count past its limit");

  a_leaf_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind_r == KIND_LEAF) |-> (out_total_r != '0))
    else $error("leaf piece sent with zero total");

  a_pend_set: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_leaf |=> pend_valid_r)
    else $error("emitted leaf not held as pending");

endmodule

@@ hdl/bsp_segment_clip_to_leaves.sv @@
// BSP segment clipper. Operation 0 and 1 write a node or plane table entry; each
// write is acknowledged by one kind 0 result in the cycle after start is taken.
// Operation 2 clips a segment against the tree from the given root, walking it
// depth first with a 32-entry work stack, and sends one kind 1 result per
// non-empty leaf reached (or one kind 2 result when none is), the final one with
// last set. Results appear for exactly one cycle each, marked by out_valid, and
// cannot be held off, so the receiver must take every transfer as it comes.
// At an internal node whose segment crosses the plane, the crossing point needs
// a normalizing shift, a restoring divider that yields a 31-bit quotient and an
// interpolation of each coordinate, and all dot products and interpolations go
// one at a time through a single shared 33 x 32 multiplier. busy stays high
// until the last result of a query has been issued; a new operation may be
// started in the cycle that result is shown.
module bsp_segment_clip_to_leaves
  import bsp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_operation,
  input  logic [9:0]         in_entry_index,
  input  logic signed [31:0] in_coord_a_x,
  input  logic signed [31:0] in_coord_a_y,
  input  logic signed [31:0] in_coord_a_z,
  input  logic signed [31:0] in_coord_b_x,
  input  logic signed [31:0] in_coord_b_y,
  input  logic signed [31:0] in_coord_b_z,
  input  logic [9:0]         in_node_plane,
  input  logic [15:0]        in_child_back,
  input  logic [15:0]        in_child_front,
  output logic               out_valid,
  output logic [1:0]         out_kind,
  output logic [14:0]        out_leaf_index,
  output logic signed [31:0] out_piece_start_x,
  output logic signed [31:0] out_piece_start_y,
  output logic signed [31:0] out_piece_start_z,
  output logic signed [31:0] out_piece_end_x,
  output logic signed [31:0] out_piece_end_y,
  output logic signed [31:0] out_piece_end_z,
  output logic               out_last,
  output logic [6:0]         out_leaf_total,
  output logic               out_overflow
);

  // The controller sequences each work item; the datapath owns the tables,
  // the stack, the multiplier and the divider.
  bsp_cmd_t    cmd;
  bsp_status_t status;

  bsp_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .status       (status),
    .cmd          (cmd),
    .busy         (busy)
  );

  bsp_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_entry_index    (in_entry_index),
    .in_coord_a_x      (in_coord_a_x),
    .in_coord_a_y      (in_coord_a_y),
    .in_coord_a_z      (in_coord_a_z),
    .in_coord_b_x      (in_coord_b_x),
    .in_coord_b_y      (in_coord_b_y),
    .in_coord_b_z      (in_coord_b_z),
    .in_node_plane     (in_node_plane),
    .in_child_back     (in_child_back),
    .in_child_front    (in_child_front),
    .out_valid         (out_valid),
    .out_kind          (out_kind),
    .out_leaf_index    (out_leaf_index),
    .out_piece_start_x (out_piece_start_x),
    .out_piece_start_y (out_piece_start_y),
    .out_piece_start_z (out_piece_start_z),
    .out_piece_end_x   (out_piece_end_x),
    .out_piece_end_y   (out_piece_end_y),
    .out_piece_end_z   (out_piece_end_z),
    .out_last          (out_last),
    .out_leaf_total    (out_leaf_total),
    .out_overflow      (out_overflow)
  );

endmodule
